FILE: sv/axis_endstop_calibration_sequencer_assert.svh
// Assertion macros shared by the calibration sequencer RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef AXIS_ENDSTOP_CALIBRATION_SEQUENCER_ASSERT_SVH
`define AXIS_ENDSTOP_CALIBRATION_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
`define ECS_ASSERT_HOLD(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecs assertion failed: same-cycle check");
`define ECS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ecs assertion failed: next-cycle check");
`else
`define ECS_ASSERT_HOLD(label, clk, rst, ante, cons)
`define ECS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/ecs_pkg.sv
// Types and constants of the endstop calibration sequencer.
// No dependencies; imported by every module of the block.
package ecs_pkg;

   localparam int ENC_FIELD_BITS = 24;
   localparam int HALF_FIELD_BITS = 23;
   localparam int MOVE_WINDOW = 10;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] CSR_MAX_SPEED = 2'd0;
   localparam logic [1:0] CSR_SPEED_STEP = 2'd1;
   localparam logic [1:0] CSR_STALL_TIMEOUT = 2'd2;
   localparam logic [1:0] CSR_TOTAL_TIMEOUT = 2'd3;

   localparam logic [7:0] RST_MAX_SPEED = 8'd255;
   localparam logic [7:0] RST_SPEED_STEP = 8'd10;
   localparam logic [15:0] RST_STALL_TIMEOUT = 16'd400;
   localparam logic [19:0] RST_TOTAL_TIMEOUT = 20'd2000;

   typedef enum logic [2:0] {
      CAUSE_NONE = 3'd0,
      CAUSE_MOTOR_INV = 3'd1,
      CAUSE_ENCODER_INV = 3'd2,
      CAUSE_TOTAL_TIMEOUT = 3'd3,
      CAUSE_STALL = 3'd4,
      CAUSE_CENTER_TIMEOUT = 3'd5
   } ecs_cause_type;

   typedef struct packed {
      logic [7:0] max_speed;
      logic [7:0] speed_step;
      logic [15:0] stall_timeout;
      logic [19:0] total_timeout;
   } ecs_cfg_type;

   typedef struct packed {
      logic op;
      logic signed [ENC_FIELD_BITS-1:0] encoder_count;
      logic left_switch;
      logic right_switch;
   } ecs_req_type;

   typedef struct packed {
      logic drive_on;
      logic drive_dir;
      logic [7:0] drive_speed;
      logic [2:0] phase;
      logic done_res;
      logic success;
      ecs_cause_type error_cause;
      logic [HALF_FIELD_BITS-1:0] half_range;
   } ecs_rsp_type;

endpackage

FILE: sv/ecs_csr.sv
// Configuration register bank of the calibration sequencer.
// Depends on ecs_pkg for register indexes, reset values and the config struct.
module ecs_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [1:0] csr_index,
   input  logic [19:0] csr_wdata,
   output ecs_pkg::ecs_cfg_type cfg
);
   import ecs_pkg::*;

   ecs_cfg_type cfg_ff;
   ecs_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_SPEED: cfg_in.max_speed = csr_wdata[7:0];
            CSR_SPEED_STEP: cfg_in.speed_step = csr_wdata[7:0];
            CSR_STALL_TIMEOUT: cfg_in.stall_timeout = csr_wdata[15:0];
            CSR_TOTAL_TIMEOUT: cfg_in.total_timeout = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed <= RST_MAX_SPEED;
         cfg_ff.speed_step <= RST_SPEED_STEP;
         cfg_ff.stall_timeout <= RST_STALL_TIMEOUT;
         cfg_ff.total_timeout <= RST_TOTAL_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/ecs_engine.sv
// Calibration state and the per-request update: speed ramp, timeouts, phases.
// Depends on ecs_pkg and the assertion macro header.
`include "axis_endstop_calibration_sequencer_assert.svh"
module ecs_engine #(
   parameter int ENCODER_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  ecs_pkg::ecs_req_type req,
   input  ecs_pkg::ecs_cfg_type cfg,
   output ecs_pkg::ecs_rsp_type rsp_next
);
   import ecs_pkg::*;

   localparam int EB = ENCODER_BITS;
   localparam int HB = ENCODER_BITS - 1;
   localparam logic signed [EB:0] WIN_POS = (EB+1)'(MOVE_WINDOW);
   localparam logic signed [EB:0] WIN_NEG = -WIN_POS;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEAVE = 3'd1,
      PH_SEEK = 3'd2,
      PH_OPPOSITE = 3'd3,
      PH_CENTER = 3'd4,
      PH_FINISHED = 3'd5
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [7:0] speed_ff, speed_in;
   logic bump_ff, bump_in;
   logic dir_ff, dir_in;
   logic [EB-1:0] zero_ff, zero_in;
   logic signed [EB-1:0] last_ff, last_in;
   logic [19:0] elapsed_ff, elapsed_in;
   logic [15:0] idle_ff, idle_in;
   logic [HB-1:0] half_ff, half_in;
   logic cfp_ff, cfp_in;
   ecs_cause_type error_ff, error_in;

   logic [EB-1:0] raw;
   logic signed [EB-1:0] pos;
   logic signed [EB:0] diff;
   logic still;
   logic [8:0] bump_sum;
   logic [7:0] bump_val;
   logic [HB-1:0] half_w;
   logic running;
   logic keep;
   logic drive;
   logic done;
   ecs_cause_type cause;

   assign raw = EB'($signed(req.encoder_count));
   assign pos = $signed(raw - zero_ff);
   assign diff = $signed({pos[EB-1], pos}) - $signed({last_ff[EB-1], last_ff});
   assign still = (diff <= WIN_POS) && (diff >= WIN_NEG);
   assign bump_sum = {1'b0, speed_ff} + {1'b0, cfg.speed_step};
   assign bump_val = (bump_sum > {1'b0, cfg.max_speed}) ? cfg.max_speed : bump_sum[7:0];
   // pos is non-negative wherever this is used, so the top bit drops out
   assign half_w = pos[EB-1:1];
   assign running = (phase_ff == PH_LEAVE) || (phase_ff == PH_SEEK) ||
                    (phase_ff == PH_OPPOSITE) || (phase_ff == PH_CENTER);
   assign keep = cfp_ff ? (pos >= 0) : (pos <= 0);

   always_comb begin
      phase_in = phase_ff;
      speed_in = speed_ff;
      bump_in = bump_ff;
      dir_in = dir_ff;
      zero_in = zero_ff;
      last_in = last_ff;
      elapsed_in = elapsed_ff;
      idle_in = idle_ff;
      half_in = half_ff;
      cfp_in = cfp_ff;
      error_in = error_ff;
      drive = 1'b0;
      done = 1'b0;
      cause = CAUSE_NONE;
      if (step_en) begin
         if (req.op == OP_START) begin
            error_in = CAUSE_NONE;
            half_in = '0;
            cfp_in = 1'b0;
            elapsed_in = '0;
            dir_in = 1'b1;
            zero_in = raw;
            last_in = '0;
            speed_in = 8'd1;
            idle_in = '0;
            bump_in = 1'b0;
            phase_in = (req.left_switch || req.right_switch) ? PH_LEAVE : PH_SEEK;
         end else if (running) begin
            // speed ramp and stall counting
            if (still) begin
               if (idle_ff != 16'hFFFF) idle_in = idle_ff + 16'd1;
               if (speed_ff < cfg.max_speed) speed_in = speed_ff + 8'd1;
            end else begin
               idle_in = '0;
               if (!bump_ff) begin
                  speed_in = bump_val;
                  bump_in = 1'b1;
               end
            end
            last_in = pos;
            if (elapsed_ff != 20'hFFFFF) elapsed_in = elapsed_ff + 20'd1;

            // stall check wins over total timeout
            if (idle_in >= cfg.stall_timeout) begin
               cause = (phase_ff == PH_CENTER) ? CAUSE_CENTER_TIMEOUT : CAUSE_STALL;
            end else if (elapsed_in >= cfg.total_timeout) begin
               cause = (phase_ff == PH_CENTER) ? CAUSE_CENTER_TIMEOUT
                                               : CAUSE_TOTAL_TIMEOUT;
            end

            if (cause != CAUSE_NONE) begin
               error_in = cause;
               phase_in = PH_IDLE;
               done = 1'b1;
            end else begin
               case (phase_ff)
                  PH_LEAVE: begin
                     if (!req.left_switch && !req.right_switch) begin
                        zero_in = raw;
                        last_in = '0;
                        speed_in = 8'd1;
                        idle_in = '0;
                        bump_in = 1'b0;
                        phase_in = PH_SEEK;
                     end else begin
                        drive = 1'b1;
                     end
                  end
                  PH_SEEK: begin
                     if (req.left_switch) begin
                        error_in = CAUSE_MOTOR_INV;
                        phase_in = PH_IDLE;
                        done = 1'b1;
                     end else if (req.right_switch) begin
                        zero_in = raw;
                        last_in = '0;
                        speed_in = 8'd1;
                        idle_in = '0;
                        bump_in = 1'b1;
                        dir_in = 1'b0;
                        phase_in = PH_OPPOSITE;
                     end else begin
                        drive = 1'b1;
                     end
                  end
                  PH_OPPOSITE: begin
                     if (!req.left_switch) begin
                        drive = 1'b1;
                     end else if (pos < 0) begin
                        error_in = CAUSE_ENCODER_INV;
                        phase_in = PH_IDLE;
                        done = 1'b1;
                     end else begin
                        // move the zero to the middle of the travel
                        half_in = half_w;
                        zero_in = raw - EB'(half_w);
                        last_in = $signed({1'b0, half_w});
                        cfp_in = (half_w != '0);
                        speed_in = 8'd1;
                        dir_in = 1'b1;
                        idle_in = '0;
                        if (req.right_switch) begin
                           phase_in = PH_FINISHED;
                           done = 1'b1;
                        end else begin
                           phase_in = PH_CENTER;
                        end
                     end
                  end
                  PH_CENTER: begin
                     if (keep && !req.right_switch) begin
                        drive = 1'b1;
                     end else begin
                        phase_in = PH_FINISHED;
                        done = 1'b1;
                     end
                  end
                  default: drive = 1'b0;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         speed_ff <= 8'd1;
         bump_ff <= 1'b0;
         dir_ff <= 1'b1;
         zero_ff <= '0;
         last_ff <= '0;
         elapsed_ff <= '0;
         idle_ff <= '0;
         half_ff <= '0;
         cfp_ff <= 1'b0;
         error_ff <= CAUSE_NONE;
      end else begin
         phase_ff <= phase_in;
         speed_ff <= speed_in;
         bump_ff <= bump_in;
         dir_ff <= dir_in;
         zero_ff <= zero_in;
         last_ff <= last_in;
         elapsed_ff <= elapsed_in;
         idle_ff <= idle_in;
         half_ff <= half_in;
         cfp_ff <= cfp_in;
         error_ff <= error_in;
      end
   end

   always_comb begin
      rsp_next.drive_on = drive;
      rsp_next.drive_dir = drive & dir_in;
      rsp_next.drive_speed = drive ? speed_in : 8'd0;
      rsp_next.phase = phase_in;
      rsp_next.done_res = done;
      rsp_next.success = (phase_in == PH_FINISHED);
      rsp_next.error_cause = error_in;
      rsp_next.half_range = HALF_FIELD_BITS'(half_in);
   end

   `ECS_ASSERT_HOLD(a_drive_only_running, clock, reset, step_en && drive, (phase_in == PH_LEAVE) || (phase_in == PH_SEEK) || (phase_in == PH_OPPOSITE) || (phase_in == PH_CENTER))
   `ECS_ASSERT_HOLD(a_done_ends_run, clock, reset, step_en && done, (phase_in == PH_IDLE) || (phase_in == PH_FINISHED))
   `ECS_ASSERT_HOLD(a_error_means_idle, clock, reset, error_ff != CAUSE_NONE, phase_ff == PH_IDLE)
   `ECS_ASSERT_NEXT(a_tick_when_stopped, clock, reset, step_en && (req.op == OP_TICK) && !running, phase_ff == $past(phase_ff))

endmodule

FILE: sv/axis_endstop_calibration_sequencer.sv
// Top level of the endstop calibration sequencer: request register, result
// register and handshakes. Depends on ecs_pkg, ecs_csr and ecs_engine.
//
//   channel   direction  handshake              payload
//   req_*     in         req_valid / req_ready  op, encoder_count, switches
//   rsp_*     out        rsp_valid / rsp_ready  drive, phase, status, half_range
//   csr_*     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A request waits in the request register while the engine evaluates it
// against the calibration state, and moves into the result register when that
// register is empty or being drained; one request per cycle sustained while
// rsp_ready stays high.
// The state update for one request is a single pass of compares, small adds
// and a one-bit shift. A stalled result holds the request register; a new
// request is still taken while the request register is free. Reset is
// synchronous and clears state, handshakes and configuration at once.
`include "axis_endstop_calibration_sequencer_assert.svh"
module axis_endstop_calibration_sequencer #(
   parameter int ENCODER_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_op,
   input  logic signed [23:0] req_encoder_count,
   input  logic req_left_switch,
   input  logic req_right_switch,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_drive_on,
   output logic rsp_drive_dir,
   output logic [7:0] rsp_drive_speed,
   output logic [2:0] rsp_phase,
   output logic rsp_done_res,
   output logic rsp_success,
   output logic [2:0] rsp_error_cause,
   output logic [22:0] rsp_half_range,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [19:0] csr_wdata
);
   import ecs_pkg::*;

   ecs_req_type in_ff;
   logic in_valid_ff, in_valid_in;
   ecs_rsp_type rsp_ff;
   logic rsp_valid_ff, rsp_valid_in;
   ecs_rsp_type rsp_next;
   ecs_cfg_type cfg;
   logic advance;
   logic req_fire;

   assign csr_ready = 1'b1;

   ecs_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   ecs_engine #(
      .ENCODER_BITS(ENCODER_BITS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .step_en(advance),
      .req(in_ff),
      .cfg(cfg),
      .rsp_next(rsp_next)
   );

   // advance when the result register is empty or being drained
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff.op <= req_op;
         in_ff.encoder_count <= req_encoder_count;
         in_ff.left_switch <= req_left_switch;
         in_ff.right_switch <= req_right_switch;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_on = rsp_ff.drive_on;
   assign rsp_drive_dir = rsp_ff.drive_dir;
   assign rsp_drive_speed = rsp_ff.drive_speed;
   assign rsp_phase = rsp_ff.phase;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_success = rsp_ff.success;
   assign rsp_error_cause = rsp_ff.error_cause;
   assign rsp_half_range = rsp_ff.half_range;

   `ECS_ASSERT_NEXT(a_held_request_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `ECS_ASSERT_NEXT(a_step_fills_result, clock, reset, advance, rsp_valid_ff)
   `ECS_ASSERT_HOLD(a_no_accept_when_full, clock, reset, in_valid_ff && !advance, !req_ready)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for axis_endstop_calibration_sequencer.
// Drives calibration runs under several register settings and checks every
// result against an in-bench model of the sequencer; depends on ecs_pkg and the sequencer top.
`timescale 1ns / 1ps
module testbench;
   import ecs_pkg::*;

   localparam int CLK_PERIOD = 4;
   localparam int TIMEOUT_CYCLES = 600000;
   localparam int PLAN_COUNT = 7;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LEAVE = 3'd1;
   localparam logic [2:0] PH_SEEK = 3'd2;
   localparam logic [2:0] PH_OPPOSITE = 3'd3;
   localparam logic [2:0] PH_CENTER = 3'd4;
   localparam logic [2:0] PH_FINISHED = 3'd5;

   logic clock;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = OP_TICK;
   logic signed [23:0] req_encoder_count = '0;
   logic req_left_switch = 1'b0;
   logic req_right_switch = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_drive_on;
   logic rsp_drive_dir;
   logic [7:0] rsp_drive_speed;
   logic [2:0] rsp_phase;
   logic rsp_done_res;
   logic rsp_success;
   logic [2:0] rsp_error_cause;
   logic [22:0] rsp_half_range;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_MAX_SPEED;
   logic [19:0] csr_wdata = '0;

   axis_endstop_calibration_sequencer i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_encoder_count(req_encoder_count),
      .req_left_switch(req_left_switch),
      .req_right_switch(req_right_switch),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive_on(rsp_drive_on),
      .rsp_drive_dir(rsp_drive_dir),
      .rsp_drive_speed(rsp_drive_speed),
      .rsp_phase(rsp_phase),
      .rsp_done_res(rsp_done_res),
      .rsp_success(rsp_success),
      .rsp_error_cause(rsp_error_cause),
      .rsp_half_range(rsp_half_range),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Calibration state mirrored from the sequencer.
   ecs_cfg_type cal_cfg;
   logic [2:0] cal_phase;
   logic [7:0] cal_speed;
   logic cal_bumped;
   logic cal_dir;
   logic [23:0] cal_zero;
   int cal_last;
   logic [19:0] cal_elapsed;
   logic [15:0] cal_idle;
   logic [22:0] cal_half;
   logic cal_from_positive;
   ecs_cause_type cal_error;

   ecs_req_type request_backlog[$];
   ecs_req_type run_steps[$];
   ecs_rsp_type expected_tick_results[$];
   int mismatch_count = 0;

   function automatic void rezero_axis(logic [23:0] raw, logic bump);
      cal_zero = raw;
      cal_last = 0;
      cal_speed = 8'd1;
      cal_idle = '0;
      cal_bumped = bump;
   endfunction

   function automatic void reset_calibration_state();
      cal_cfg.max_speed = RST_MAX_SPEED;
      cal_cfg.speed_step = RST_SPEED_STEP;
      cal_cfg.stall_timeout = RST_STALL_TIMEOUT;
      cal_cfg.total_timeout = RST_TOTAL_TIMEOUT;
      cal_phase = PH_IDLE;
      cal_dir = 1'b1;
      cal_elapsed = '0;
      cal_half = '0;
      cal_from_positive = 1'b0;
      cal_error = CAUSE_NONE;
      rezero_axis('0, 1'b0);
   endfunction

   function automatic ecs_rsp_type step_calibration(ecs_req_type rq);
      ecs_rsp_type res;
      logic [23:0] raw;
      logic signed [23:0] pos;
      int pos_i;
      int delta;
      int bumped_speed;
      logic drive;
      logic done;
      logic keep;
      ecs_cause_type cause;
      raw = rq.encoder_count;
      pos = raw - cal_zero;
      pos_i = pos;
      drive = 1'b0;
      done = 1'b0;
      cause = CAUSE_NONE;
      if (rq.op == OP_START) begin
         cal_error = CAUSE_NONE;
         cal_half = '0;
         cal_from_positive = 1'b0;
         cal_elapsed = '0;
         cal_dir = 1'b1;
         rezero_axis(raw, 1'b0);
         cal_phase = (rq.left_switch || rq.right_switch) ? PH_LEAVE : PH_SEEK;
      end else if (cal_phase >= PH_LEAVE && cal_phase <= PH_CENTER) begin
         delta = pos_i - cal_last;
         if (delta < 0) delta = -delta;
         if (delta <= MOVE_WINDOW) begin
            if (cal_idle != 16'hFFFF) cal_idle++;
            if (cal_speed < cal_cfg.max_speed) cal_speed++;
         end else begin
            cal_idle = '0;
            if (!cal_bumped) begin
               bumped_speed = int'(cal_speed) + int'(cal_cfg.speed_step);
               cal_speed = (bumped_speed > int'(cal_cfg.max_speed)) ?
                  cal_cfg.max_speed : 8'(bumped_speed);
               cal_bumped = 1'b1;
            end
         end
         cal_last = pos_i;
         if (cal_elapsed != 20'hFFFFF) cal_elapsed++;

         // stall wins over total; both report as centering timeout in center
         if (cal_idle >= cal_cfg.stall_timeout)
            cause = (cal_phase == PH_CENTER) ? CAUSE_CENTER_TIMEOUT : CAUSE_STALL;
         else if (cal_elapsed >= cal_cfg.total_timeout)
            cause = (cal_phase == PH_CENTER) ? CAUSE_CENTER_TIMEOUT : CAUSE_TOTAL_TIMEOUT;

         if (cause != CAUSE_NONE) begin
            cal_error = cause;
            cal_phase = PH_IDLE;
            done = 1'b1;
         end else if (cal_phase == PH_LEAVE) begin
            if (!rq.left_switch && !rq.right_switch) begin
               rezero_axis(raw, 1'b0);
               cal_phase = PH_SEEK;
            end else begin
               drive = 1'b1;
            end
         end else if (cal_phase == PH_SEEK) begin
            if (rq.left_switch) begin
               cal_error = CAUSE_MOTOR_INV;
               cal_phase = PH_IDLE;
               done = 1'b1;
            end else if (rq.right_switch) begin
               rezero_axis(raw, 1'b1);
               cal_dir = 1'b0;
               cal_phase = PH_OPPOSITE;
            end else begin
               drive = 1'b1;
            end
         end else if (cal_phase == PH_OPPOSITE) begin
            if (!rq.left_switch) begin
               drive = 1'b1;
            end else if (pos_i < 0) begin
               cal_error = CAUSE_ENCODER_INV;
               cal_phase = PH_IDLE;
               done = 1'b1;
            end else begin
               // re-center the position frame on the midpoint of the travel
               cal_half = 23'(pos_i >> 1);
               cal_zero = raw - {1'b0, cal_half};
               cal_last = int'(cal_half);
               cal_from_positive = (cal_half != '0);
               cal_speed = 8'd1;
               cal_dir = 1'b1;
               cal_idle = '0;
               if (rq.right_switch) begin
                  cal_phase = PH_FINISHED;
                  done = 1'b1;
               end else begin
                  cal_phase = PH_CENTER;
               end
            end
         end else begin
            keep = cal_from_positive ? (pos_i >= 0) : (pos_i <= 0);
            if (keep && !rq.right_switch) begin
               drive = 1'b1;
            end else begin
               cal_phase = PH_FINISHED;
               done = 1'b1;
            end
         end
      end
      res.drive_on = drive;
      res.drive_dir = drive ? cal_dir : 1'b0;
      res.drive_speed = drive ? cal_speed : 8'd0;
      res.phase = cal_phase;
      res.done_res = done;
      res.success = (cal_phase == PH_FINISHED);
      res.error_cause = cal_error;
      res.half_range = cal_half;
      return res;
   endfunction

   function automatic void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s: expected %0d, actual %0d", name, expv, actv);
         mismatch_count++;
      end
   endfunction

   // Result monitor and request/register observer.
   ecs_rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         reset_calibration_state();
         expected_tick_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tick_results.size() == 0) begin
               $error("result with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_tick_results.pop_front();
               compare_field("drive_on", want.drive_on, rsp_drive_on);
               compare_field("drive_dir", want.drive_dir, rsp_drive_dir);
               compare_field("drive_speed", want.drive_speed, rsp_drive_speed);
               compare_field("phase", want.phase, rsp_phase);
               compare_field("done_res", want.done_res, rsp_done_res);
               compare_field("success", want.success, rsp_success);
               compare_field("error_cause", want.error_cause, rsp_error_cause);
               compare_field("half_range", want.half_range, rsp_half_range);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_SPEED: cal_cfg.max_speed = csr_wdata[7:0];
               CSR_SPEED_STEP: cal_cfg.speed_step = csr_wdata[7:0];
               CSR_STALL_TIMEOUT: cal_cfg.stall_timeout = csr_wdata[15:0];
               CSR_TOTAL_TIMEOUT: cal_cfg.total_timeout = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_tick_results.push_back(step_calibration(
               '{req_op, req_encoder_count, req_left_switch, req_right_switch}));
      end
   end

   // Request driver: bursts of random length separated by random gaps.
   ecs_req_type next_req;
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            next_req = request_backlog.pop_front();
            req_valid <= 1'b1;
            req_op <= next_req.op;
            req_encoder_count <= next_req.encoder_count;
            req_left_switch <= next_req.left_switch;
            req_right_switch <= next_req.right_switch;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result backpressure: a repeating 13-bit ready pattern, periodically redrawn at random.
   logic [12:0] ready_pattern = '1;
   int ready_slot = 0;
   int ready_cycles = 0;
   always @(posedge clock) begin
      rsp_ready <= ready_pattern[ready_slot];
      ready_slot = (ready_slot + 1) % 13;
      ready_cycles++;
      if (ready_cycles % 256 == 0)
         ready_pattern = ($urandom_range(0, 2) == 0) ? '1 : (13'($urandom) | 13'd1);
   end

   function automatic void queue_request(logic op, logic [23:0] enc, logic lsw, logic rsw);
      ecs_req_type rq;
      rq.op = op;
      rq.encoder_count = enc;
      rq.left_switch = lsw;
      rq.right_switch = rsw;
      run_steps.push_back(rq);
   endfunction

   // Move the staged run to the backlog, cutting it short now and then.
   function automatic int commit_run(bit may_cut);
      int keep_len;
      keep_len = run_steps.size();
      if (may_cut && keep_len > 1 && $urandom_range(0, 7) == 0)
         keep_len = $urandom_range(1, keep_len - 1);
      for (int i = 0; i < keep_len; i++) request_backlog.push_back(run_steps[i]);
      run_steps.delete();
      return keep_len;
   endfunction

   function automatic logic [23:0] travel_step();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return 24'($urandom_range(0, MOVE_WINDOW));
      if (pick < 9) return 24'($urandom_range(MOVE_WINDOW + 1, 3000));
      return 24'($urandom_range(3000, 400000));
   endfunction

   // One plausible calibration: leave, seek right, back to left, center.
   function automatic void build_calibration_run();
      logic [23:0] enc;
      logic [23:0] right_pos;
      logic [23:0] center_pos;
      logic lsw;
      logic rsw;
      int guard;
      enc = 24'($urandom);
      lsw = 1'b0;
      rsw = 1'b0;
      case ($urandom_range(0, 3))
         0: lsw = 1'b1;
         1: rsw = 1'b1;
         2: begin
            lsw = 1'b1;
            rsw = 1'b1;
         end
         default: ;
      endcase
      queue_request(OP_START, enc, lsw, rsw);
      if (lsw || rsw) begin
         repeat ($urandom_range(0, 3)) begin
            enc = enc + 24'($urandom_range(0, 30)) - 24'd15;
            queue_request(OP_TICK, enc, lsw, rsw);
         end
         queue_request(OP_TICK, enc, 1'b0, 1'b0);
      end
      repeat ($urandom_range(0, 10)) begin
         enc = enc + travel_step();
         queue_request(OP_TICK, enc, 1'b0, 1'b0);
      end
      if ($urandom_range(0, 9) == 0) begin
         // wrong switch first: motor wired backwards
         queue_request(OP_TICK, enc, 1'b1, 1'($urandom_range(0, 1)));
         return;
      end
      queue_request(OP_TICK, enc, 1'b0, 1'b1);
      right_pos = enc;
      repeat ($urandom_range(0, 12)) begin
         enc = enc + travel_step();
         queue_request(OP_TICK, enc, 1'b0, 1'($urandom_range(0, 9) == 0));
      end
      // land below the right switch point: encoder counts backwards
      if ($urandom_range(0, 9) == 0) enc = right_pos - 24'($urandom_range(1, 100000));
      queue_request(OP_TICK, enc, 1'b1, 1'($urandom_range(0, 15) == 0));
      center_pos = enc - ((enc - right_pos) >> 1);
      guard = 0;
      while ($signed(enc - center_pos) >= 0 && guard < 40) begin
         enc = enc - travel_step();
         queue_request(OP_TICK, enc, 1'b0, 1'($urandom_range(0, 30) == 0));
         guard++;
      end
      queue_request(OP_TICK, enc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endfunction

   function automatic void add_random_traffic(int target);
      int added;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 5))
               queue_request(1'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
            added += commit_run(1'b0);
         end else begin
            build_calibration_run();
            added += commit_run(1'b1);
         end
      end
   endfunction

   function automatic void add_directed_checks();
      int unused;
      // ticks while idle are ignored
      queue_request(OP_TICK, 24'h7FFFFF, 1'b1, 1'b1);
      queue_request(OP_TICK, 24'h800000, 1'b0, 1'b0);
      // full run across the encoder wrap point
      queue_request(OP_START, 24'h7FFFF0, 1'b1, 1'b0);
      queue_request(OP_TICK, 24'h7FFFF5, 1'b1, 1'b0);
      queue_request(OP_TICK, 24'h7FFFFA, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h800100, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h800105, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h800200, 1'b0, 1'b1);
      queue_request(OP_TICK, 24'h800300, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h801000, 1'b1, 1'b0);
      queue_request(OP_TICK, 24'h800C00, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h800800, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h800700, 1'b1, 1'b0);
      // restart in the middle of a run, then the motor-inverted error
      queue_request(OP_START, 24'h000000, 1'b0, 1'b1);
      queue_request(OP_START, 24'h000000, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h000005, 1'b1, 1'b0);
      // encoder inverted
      queue_request(OP_START, 24'h000100, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h000200, 1'b0, 1'b1);
      queue_request(OP_TICK, 24'h000100, 1'b1, 1'b0);
      // widest travel, right switch on centering entry finishes at once
      queue_request(OP_START, 24'h000000, 1'b0, 1'b0);
      queue_request(OP_TICK, 24'h000000, 1'b0, 1'b1);
      queue_request(OP_TICK, 24'h7FFFFE, 1'b1, 1'b1);
      queue_request(OP_TICK, 24'h7FFFFF, 1'b0, 1'b0);
      unused = commit_run(1'b0);
   endfunction

   function automatic ecs_cfg_type make_cfg(int ms, int st, int stall, int total);
      ecs_cfg_type c;
      c.max_speed = 8'(ms);
      c.speed_step = 8'(st);
      c.stall_timeout = 16'(stall);
      c.total_timeout = 20'(total);
      return c;
   endfunction

   task automatic write_register(input logic [1:0] idx, input logic [19:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic program_registers(input ecs_cfg_type c);
      write_register(CSR_MAX_SPEED, {12'd0, c.max_speed});
      write_register(CSR_SPEED_STEP, {12'd0, c.speed_step});
      write_register(CSR_STALL_TIMEOUT, {4'd0, c.stall_timeout});
      write_register(CSR_TOTAL_TIMEOUT, c.total_timeout);
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || expected_tick_results.size() != 0)
         @(negedge clock);
   endtask

   ecs_cfg_type reg_plan[PLAN_COUNT];
   int traffic_share[PLAN_COUNT];

   initial begin
      reg_plan[0] = make_cfg(255, 10, 400, 2000);
      reg_plan[1] = make_cfg(1, 0, 1, 1);
      reg_plan[2] = make_cfg(0, 255, 0, 0);
      reg_plan[3] = make_cfg(0, 200, 65535, 1048575);
      reg_plan[4] = make_cfg(255, 255, 65535, 1048575);
      reg_plan[5] = make_cfg($urandom_range(1, 255), $urandom_range(0, 255),
                             $urandom_range(2, 20), $urandom_range(15, 150));
      reg_plan[6] = make_cfg($urandom_range(1, 255), $urandom_range(0, 255),
                             $urandom_range(20, 500), $urandom_range(100, 3000));
      traffic_share = '{250, 80, 80, 200, 200, 220, 220};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      add_directed_checks();
      wait_until_idle();
      for (int p = 0; p < PLAN_COUNT; p++) begin
         program_registers(reg_plan[p]);
         add_random_traffic(traffic_share[p]);
         wait_until_idle();
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/ecs_pkg.sv
sv/ecs_csr.sv
sv/ecs_engine.sv
sv/axis_endstop_calibration_sequencer.sv
tb/testbench.sv
